/* rtl/versioned_prefix_max_tree_macros.svh */
// Assertion macros used by the top-level file that checks this block.
`ifndef VERSIONED_PREFIX_MAX_TREE_MACROS_SVH
`define VERSIONED_PREFIX_MAX_TREE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VPMT_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vpmt same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VPMT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vpmt next-cycle check failed");

`endif

/* rtl/vpmt_pkg.sv */
`timescale 1ns / 1ps

package vpmt_pkg;

   // Port widths of the request and response channels.
   localparam int OP_W  = 2;
   localparam int POS_W = 10;
   localparam int VAL_W = 16;

   // Defaults for the top-level parameters.
   localparam int POSITIONS_DEF  = 1024;
   localparam int VALUE_BITS_DEF = 16;
   localparam int EPOCH_BITS_DEF = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic epoch_step;
      logic walk_upd;
      logic walk_qry;
      logic clear_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_range;
      logic epoch_wrap;
      logic up_last;
      logic qry_last;
      logic clear_last;
   } stat_type;

endpackage

/* rtl/vpmt_datapath.sv */
`timescale 1ns / 1ps

module vpmt_datapath
   import vpmt_pkg::*;
#(
   parameter int POSITIONS  = POSITIONS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int EPOCH_BITS = EPOCH_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [POS_W-1:0] req_position,
   input  logic [VAL_W-1:0] req_value,
   output logic [VAL_W-1:0] rsp_max_value,
   output logic             rsp_has_value
);

   localparam int ADDR_W = $clog2(POSITIONS);
   localparam int KW     = $clog2(POSITIONS + 1);
   localparam int KW1    = KW + 1;
   localparam int WORD_W = EPOCH_BITS + VALUE_BITS;
   localparam logic [31:0] POS_LIMIT = 32'(POSITIONS);

   logic [WORD_W-1:0]     node_mem_ff [POSITIONS];
   logic [WORD_W-1:0]     rd_data_ff;
   logic [KW-1:0]         k_ff, k_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic                  found_ff, found_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;

   logic [31:0]           k_wide;
   logic [KW-1:0]         k_start;
   logic [KW-1:0]         lowbit;
   logic [KW1-1:0]        k_up;
   logic [KW-1:0]         k_dn;
   logic [EPOCH_BITS-1:0] node_epoch;
   logic [VALUE_BITS-1:0] node_val;
   logic                  match;
   logic [VALUE_BITS-1:0] merged;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [ADDR_W-1:0]     rd_addr;

   // Node index is one-based; a query prefix saturates at the last node.
   assign k_wide  = 32'(req_position) + 32'd1;
   assign k_start = (k_wide > POS_LIMIT) ? KW'(POS_LIMIT) : KW'(k_wide);

   assign lowbit = k_ff & (~k_ff + KW'(1));
   assign k_up   = {1'b0, k_ff} + {1'b0, lowbit};
   assign k_dn   = k_ff - lowbit;

   assign node_epoch = rd_data_ff[WORD_W-1:VALUE_BITS];
   assign node_val   = rd_data_ff[VALUE_BITS-1:0];
   assign match      = (node_epoch == epoch_ff);
   assign merged     = (match && (node_val > value_ff)) ? node_val : value_ff;

   assign stat.in_range   = (k_wide <= POS_LIMIT);
   assign stat.epoch_wrap = &epoch_ff;
   assign stat.up_last    = (k_up > KW1'(POS_LIMIT));
   assign stat.qry_last   = (k_dn == '0);
   assign stat.clear_last = (clr_ff == ADDR_W'(POSITIONS - 1));

   assign wr_en   = cmd.clear_step | cmd.walk_upd;
   assign wr_addr = cmd.clear_step ? clr_ff : ADDR_W'(k_ff - KW'(1));
   assign wr_data = cmd.clear_step ? '0 : {epoch_ff, merged};

   // During an update walk, the next node is read while the current one is written back.
   always_comb begin
      if (cmd.walk_upd) begin
         rd_addr = ADDR_W'(k_up - KW1'(1));
      end else if (cmd.walk_qry) begin
         rd_addr = ADDR_W'(k_dn - KW'(1));
      end else begin
         rd_addr = ADDR_W'(k_ff - KW'(1));
      end
   end

   always_comb begin
      k_in     = k_ff;
      value_in = value_ff;
      best_in  = best_ff;
      found_in = found_ff;
      epoch_in = epoch_ff;
      clr_in   = clr_ff;
      if (cmd.load) begin
         k_in     = k_start;
         value_in = VALUE_BITS'(req_value);
         best_in  = '0;
         found_in = 1'b0;
      end
      if (cmd.epoch_step) begin
         epoch_in = epoch_ff + EPOCH_BITS'(1);
      end
      if (cmd.walk_upd) begin
         k_in = KW'(k_up);
      end
      if (cmd.walk_qry) begin
         k_in = k_dn;
         if (match) begin
            found_in = 1'b1;
            if (!found_ff || (node_val > best_ff)) begin
               best_in = node_val;
            end
         end
      end
      if (cmd.clear_step) begin
         clr_in = stat.clear_last ? '0 : clr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= node_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         found_ff <= 1'b0;
         epoch_ff <= '0;
         clr_ff   <= '0;
      end else begin
         best_ff  <= best_in;
         found_ff <= found_in;
         epoch_ff <= epoch_in;
         clr_ff   <= clr_in;
      end
   end

   assign rsp_max_value = VAL_W'(best_ff);
   assign rsp_has_value = found_ff;

endmodule

/* rtl/vpmt_ctrl.sv */
`timescale 1ns / 1ps

module vpmt_ctrl
   import vpmt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [OP_W-1:0] req_op,
   input  stat_type        stat,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      upd_ff, upd_in;
   logic      wipe_ff, wipe_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      upd_in   = upd_ff;
      wipe_in  = wipe_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_op)
                  OP_UPDATE: begin
                     upd_in   = 1'b1;
                     state_in = stat.in_range ? ST_READ : ST_DONE;
                  end
                  OP_QUERY: begin
                     upd_in   = 1'b0;
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     cmd.epoch_step = 1'b1;
                     wipe_in        = stat.epoch_wrap;
                     state_in       = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (upd_ff) begin
               cmd.walk_upd = 1'b1;
               if (stat.up_last) begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.walk_qry = 1'b1;
               if (stat.qry_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            wipe_in  = 1'b0;
            state_in = wipe_ff ? ST_CLEAR : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         upd_ff   <= 1'b0;
         wipe_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         upd_ff   <= upd_in;
         wipe_ff  <= wipe_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

/* rtl/versioned_prefix_max_tree.sv */
`timescale 1ns / 1ps
// Prefix-maximum Fenwick tree with epoch-stamped nodes. A beat is taken when start is
// high and busy is low; its single response beat appears on the rsp_ ports for exactly
// one cycle, flagged by rsp_valid, and the receiver cannot stall it, so it must take the
// response in that cycle. After the edge that accepts an update or query, busy stays
// high through a first read state, one walk step for each of the N tree nodes on its
// path (at most log2(POSITIONS) + 1, so 11 for 1024 positions) and the response state,
// so no new beat is taken before that response. Each step is paced by the single node
// memory, which is read once per step and, for an update, also written. A clear, the
// unused op code and an update beyond the last position go straight to the response
// state. The response strobe is in the last busy cycle of its beat, except after a
// clear whose epoch wraps, where the sweep follows it. After reset, and after a
// clear whose epoch wraps to zero, the block sweeps the node memory back to value 0 at
// epoch 0, one node per cycle, keeping busy high until the last node is cleared.
`include "versioned_prefix_max_tree_macros.svh"

module versioned_prefix_max_tree
   import vpmt_pkg::*;
#(
   parameter int POSITIONS  = POSITIONS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int EPOCH_BITS = EPOCH_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_op,
   input  logic [POS_W-1:0] req_position,
   input  logic [VAL_W-1:0] req_value,
   output logic             rsp_valid,
   output logic [VAL_W-1:0] rsp_max_value,
   output logic             rsp_has_value
);

   // The controller sequences each beat; the datapath holds the node memory,
   // the walk index, the running maximum and the current epoch.
   cmd_type  cmd;
   stat_type stat;

   vpmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   vpmt_datapath #(
      .POSITIONS  (POSITIONS),
      .VALUE_BITS (VALUE_BITS),
      .EPOCH_BITS (EPOCH_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_max_value (rsp_max_value),
      .rsp_has_value (rsp_has_value)
   );

   // A response strobe lasts a single cycle.
   `VPMT_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   // An accepted beat keeps the block busy in the following cycle.
   `VPMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // A response only appears while a beat is being worked on.
   `VPMT_ASSERT_SAME(a_rsp_busy, rsp_valid, busy)
   // A query needs its memory walk, so it never answers in the next cycle.
   `VPMT_ASSERT_NEXT(a_query_walks, start && !busy && (req_op == OP_QUERY), !rsp_valid)

endmodule
